/* src/lkv_pkg.sv */
// Shared constants for the LRU key-value cache.
package lkv_pkg;

    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

endpackage

/* src/lkv_req_if.sv */
// Request and response channel interfaces for the LRU key-value cache.
interface lkv_req_if
    import lkv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [KEY_W-1:0] req_key;
    logic signed [VAL_W-1:0] write_value;

    modport source (output valid, output op, output req_key, output write_value, input ready);
    modport sink   (input valid, input op, input req_key, input write_value, output ready);
endinterface

interface lkv_rsp_if
    import lkv_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

/* src/lkv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lru_key_value_cache.sv */
// LRU key-value cache top level: scan sequencer, recency update and result register.
// One request is handled at a time: a scan over the valid slots reads one key,
// value and rank per cycle (stops early on a hit), then, except on a get miss, a
// recency pass rewrites every valid rank one per cycle through the rank RAM. The
// single read port of each RAM sets the pace of both passes. The result sits in an
// output register, so the next request is taken while it waits. No clearing pass
// after reset.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    lkv_req_if.sink          i_req,
    lkv_rsp_if.source        o_rsp
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_DECIDE  = 5'b00100,
        S_PROMOTE = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic             r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_wval, n_wval;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_paddr, n_paddr;
    logic             r_hit, n_hit;
    logic [IW-1:0]    r_slot, n_slot;
    logic [CW-1:0]    r_old_rank, n_old_rank;
    logic [VAL_W-1:0] r_rdval, n_rdval;
    logic [IW-1:0]    r_victim, n_victim;
    logic [CW-1:0]    r_count, n_count;
    logic [CAP_W-1:0] r_cap, n_cap;
    logic             r_out_valid, n_out_valid;
    logic             r_out_found, n_out_found;
    logic [VAL_W-1:0] r_out_value, n_out_value;

    logic [KEY_W-1:0] w_rd_key;
    logic [VAL_W-1:0] w_rd_val;
    logic [IW-1:0]    w_rd_rank;
    logic             w_issue;
    logic             w_key_match;
    logic [CW-1:0]    w_cap_eff;
    logic             w_key_we, w_val_we, w_rank_we;
    logic [IW-1:0]    w_kv_waddr;
    logic [IW-1:0]    w_rank_wdata;

    lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_kv_waddr),
        .i_wdata (r_key),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rd_key)
    );

    lkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_kv_waddr),
        .i_wdata (r_wval),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rd_val)
    );

    lkv_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_rank_we),
        .i_waddr (r_paddr),
        .i_wdata (w_rank_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rd_rank)
    );

    assign w_issue     = (r_idx < r_count);
    assign w_key_match = r_pend && (w_rd_key == r_key);

    always_comb begin
        if (r_cap == '0) begin
            w_cap_eff = CW'(1);
        end else if (32'(r_cap) > ENTRIES) begin
            w_cap_eff = CW'(ENTRIES);
        end else begin
            w_cap_eff = CW'(r_cap);
        end
    end

    always_comb begin
        if (r_paddr == r_slot) begin
            w_rank_wdata = '0;
        end else if (CW'(w_rd_rank) < r_old_rank) begin
            w_rank_wdata = w_rd_rank + IW'(1);
        end else begin
            w_rank_wdata = w_rd_rank;
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_out_found;
    assign o_rsp.read_value = r_out_value;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_wval      = r_wval;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_paddr     = r_paddr;
        n_hit       = r_hit;
        n_slot      = r_slot;
        n_old_rank  = r_old_rank;
        n_rdval     = r_rdval;
        n_victim    = r_victim;
        n_count     = r_count;
        n_cap       = i_cfg_we ? i_cfg_wdata : r_cap;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_found = r_out_found;
        n_out_value = r_out_value;
        w_key_we    = 1'b0;
        w_val_we    = 1'b0;
        w_rank_we   = 1'b0;
        w_kv_waddr  = r_slot;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.op;
                    n_key   = i_req.req_key;
                    n_wval  = i_req.write_value;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_hit   = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_pend  = w_issue;
                n_paddr = r_idx[IW-1:0];
                if (w_issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_pend && (CW'(w_rd_rank) == r_count - CW'(1))) begin
                    n_victim = r_paddr;
                end
                if (w_key_match) begin
                    n_hit      = 1'b1;
                    n_slot     = r_paddr;
                    n_old_rank = CW'(w_rd_rank);
                    n_rdval    = w_rd_val;
                    n_state    = S_DECIDE;
                end else if (!w_issue && !r_pend) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_idx   = '0;
                n_pend  = 1'b0;
                n_state = S_PROMOTE;
                if (r_op == OP_GET) begin
                    if (!r_hit) begin
                        n_state = S_DONE;
                    end
                end else if (r_hit) begin
                    w_val_we = 1'b1;
                end else if (r_count < w_cap_eff) begin
                    w_key_we   = 1'b1;
                    w_val_we   = 1'b1;
                    w_kv_waddr = r_count[IW-1:0];
                    n_slot     = r_count[IW-1:0];
                    n_old_rank = r_count;
                    n_count    = r_count + CW'(1);
                end else begin
                    w_key_we   = 1'b1;
                    w_val_we   = 1'b1;
                    w_kv_waddr = r_victim;
                    n_slot     = r_victim;
                    n_old_rank = r_count - CW'(1);
                end
            end
            S_PROMOTE: begin
                n_pend    = w_issue;
                n_paddr   = r_idx[IW-1:0];
                w_rank_we = r_pend;
                if (w_issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (!w_issue && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_hit;
                    n_out_value = ((r_op == OP_GET) && r_hit) ? r_rdval : MISS_VALUE;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_key       <= n_key;
        r_wval      <= n_wval;
        r_idx       <= n_idx;
        r_paddr     <= n_paddr;
        r_hit       <= n_hit;
        r_slot      <= n_slot;
        r_old_rank  <= n_old_rank;
        r_rdval     <= n_rdval;
        r_victim    <= n_victim;
        r_out_found <= n_out_found;
        r_out_value <= n_out_value;
    end

`ifndef SYNTH
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count above table size");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count >= $past(r_count))
        else $error("entry count shrank");

    a_count_only_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ($past(r_state) == S_DECIDE) && (r_count == $past(r_count) + CW'(1)))
        else $error("entry count changed outside a fill");

    a_promote_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROMOTE) |-> (r_hit || (r_op == OP_SET)) && (r_count != '0))
        else $error("recency pass without a touched entry");
`endif

endmodule

/* tb/lkv_cache_checker.sv */
// Checker for the LRU key-value cache: predicts each reply from the observed requests and compares.
module lkv_cache_checker
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    lkv_req_if               i_req,
    lkv_rsp_if               i_rsp,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct {
        logic             found;
        logic [VAL_W-1:0] read_value;
        logic [KEY_W-1:0] req_key;
    } t_reply;

    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [VAL_W-1:0] val_mem [ENTRIES];
    int               age_mem [ENTRIES];
    int               used_slots;
    logic [CAP_W-1:0] capacity;
    t_reply           replies_q [$];
    t_reply           want;
    t_reply           next_reply;
    int               fails   = 0;
    int               waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    // slot becomes most recent; every entry newer than it ages by one
    task automatic make_newest(input int slot, input int old_age);
        for (int i = 0; i < used_slots; i++) begin
            if (i != slot && age_mem[i] < old_age) begin
                age_mem[i]++;
            end
        end
        age_mem[slot] = 0;
    endtask

    task automatic predict_access(input logic op, input logic [KEY_W-1:0] key,
                                  input logic [VAL_W-1:0] wval, output t_reply rep);
        int hit;
        int limit;
        int victim;
        int oldest;
        hit = -1;
        for (int i = 0; i < used_slots; i++) begin
            if (hit < 0 && key_mem[i] == key) begin
                hit = i;
            end
        end
        rep.found      = (hit >= 0);
        rep.read_value = MISS_VALUE;
        rep.req_key    = key;
        limit = int'(capacity);
        if (limit < 1) limit = 1;
        if (limit > ENTRIES) limit = ENTRIES;
        if (hit >= 0) begin
            if (op == OP_GET) begin
                rep.read_value = val_mem[hit];
            end else begin
                val_mem[hit] = wval;
            end
            make_newest(hit, age_mem[hit]);
        end else if (op == OP_SET) begin
            if (used_slots < limit) begin
                key_mem[used_slots] = key;
                val_mem[used_slots] = wval;
                age_mem[used_slots] = used_slots;
                used_slots++;
                make_newest(used_slots - 1, used_slots - 1);
            end else begin
                victim = 0;
                oldest = 0;
                for (int i = 0; i < used_slots; i++) begin
                    if (age_mem[i] >= oldest) begin
                        oldest = age_mem[i];
                        victim = i;
                    end
                end
                key_mem[victim] = key;
                val_mem[victim] = wval;
                make_newest(victim, oldest);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            used_slots = 0;
            capacity   = CAP_RESET;
            replies_q.delete();
        end else begin
            if (i_cfg_we) begin
                capacity = i_cfg_wdata;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (replies_q.size() == 0) begin
                    report_mismatch($sformatf("reply with none outstanding: found=%0b value=%h",
                                              i_rsp.found, i_rsp.read_value));
                end else begin
                    want = replies_q.pop_front();
                    if (i_rsp.found !== want.found) begin
                        report_mismatch($sformatf("key %h: found %0b, expected %0b",
                                                  want.req_key, i_rsp.found, want.found));
                    end
                    if (i_rsp.read_value !== want.read_value) begin
                        report_mismatch($sformatf("key %h: value %h, expected %h",
                                                  want.req_key, i_rsp.read_value,
                                                  want.read_value));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_access(i_req.op, i_req.req_key, i_req.write_value, next_reply);
                replies_q.push_back(next_reply);
            end
        end
        waiting = replies_q.size();
    end

endmodule

/* tb/tb_lru_key_value_cache.sv */
// Testbench top for the LRU key-value cache: reset, capacity settings, request stimulus, verdict.
module tb_lru_key_value_cache;
    import lkv_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SEGMENT_ITEMS = 84;
    localparam int SEGMENTS      = 9;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles = 0;
    int seg_caps [SEGMENTS] = '{16, 1, 5, 31, 0, 9, 3, 16, 12};

    logic [KEY_W-1:0] key_pool [$];

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();

    lru_key_value_cache u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    lkv_cache_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] wval);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.req_key     <= key;
        req_ch.write_value <= wval;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // pool mixes random keys, single-bit neighbors of one base key, extremes and small keys
    task automatic fill_key_pool(input int size);
        logic [KEY_W-1:0] base;
        base = $urandom;
        key_pool.delete();
        for (int i = 0; i < size; i++) begin
            case ($urandom_range(3))
                0: key_pool.push_back(base ^ (32'h1 << $urandom_range(31)));
                1: key_pool.push_back($urandom);
                2: begin
                    case ($urandom_range(3))
                        0: key_pool.push_back(32'h8000_0000);
                        1: key_pool.push_back(32'h7fff_ffff);
                        2: key_pool.push_back(32'h0000_0000);
                        default: key_pool.push_back(32'hffff_ffff);
                    endcase
                end
                default: key_pool.push_back($urandom_range(7));
            endcase
        end
    endtask

    task automatic run_segment(input int n, input int cap);
        logic [KEY_W-1:0] key;
        int               limit;
        limit = (cap < 1) ? 1 : ((cap > ENTRIES_DEFAULT) ? ENTRIES_DEFAULT : cap);
        fill_key_pool(limit + $urandom_range(1, 6));
        repeat (n) begin
            if ($urandom_range(9) == 0) begin
                key = $urandom;
            end else begin
                key = key_pool[$urandom_range(key_pool.size() - 1)];
            end
            send_request(($urandom_range(1) == 1) ? OP_SET : OP_GET, key, $urandom);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_GET;
        req_ch.req_key     = '0;
        req_ch.write_value = '0;
        send_idle_pct      = 27;
        recv_idle_pct      = 62;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty cache, extreme keys and values, overwrite, near-miss key
        send_request(OP_GET, 32'h0000_0000, 32'h1111_1111);
        send_request(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
        send_request(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
        send_request(OP_SET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_SET, 32'hffff_ffff, 32'hffff_ffff);
        send_request(OP_GET, 32'h8000_0000, 32'h0);
        send_request(OP_GET, 32'h7fff_fffe, 32'h0);
        send_request(OP_SET, 32'h0000_0000, 32'h1234_5678);
        send_request(OP_GET, 32'h0000_0000, 32'h0);
        send_request(OP_GET, 32'hffff_ffff, 32'h0);

        // capacity lowered below the entry count
        write_capacity(5'd2);
        send_request(OP_SET, 32'h5555_5555, 32'haaaa_aaaa);
        send_request(OP_GET, 32'h7fff_ffff, 32'h0);
        send_request(OP_SET, 32'haaaa_aaaa, 32'h5555_5555);
        send_request(OP_GET, 32'h5555_5555, 32'h0);

        // capacity zero acts as one
        write_capacity(5'd0);
        send_request(OP_SET, 32'h0000_0001, 32'h0000_0001);
        send_request(OP_GET, 32'h0000_0001, 32'h0);

        // capacity above the entry count saturates: fill, then evict
        write_capacity(5'd31);
        for (int i = 0; i < 13; i++) begin
            send_request(OP_SET, 32'h0000_0100 + i, $urandom);
        end
        send_request(OP_GET, 32'h0000_0100, 32'h0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 27;
            end else if (seg == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(CAP_W'(seg_caps[seg]));
            run_segment(SEGMENT_ITEMS, seg_caps[seg]);
        end

        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
